[rtl/core/plid_pkg.sv]
// Package for the positional list block: sizes, codes and request/result types.
// No dependencies; used by every module of the block.
package plid_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = 5;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE         = 2'd0,
    STATUS_BAD_POSITION = 2'd1,
    STATUS_FULL         = 2'd2
  } status_t;

  typedef struct packed {
    logic               command;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         length_after;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

[rtl/core/plid_ctrl.sv]
// Controller for the positional list block: accepts a request, steps the datapath.
// Depends on plid_pkg.
module plid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output plid_pkg::ctrl_t   ctrl
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = (state == ST_EXEC);
  assign ctrl.load = (state == ST_IDLE) && start;
  assign ctrl.exec = (state == ST_EXEC);

endmodule

[rtl/core/plid_datapath.sv]
// Datapath for the positional list block: request register, element cells,
// length count and result register. Depends on plid_pkg.
module plid_datapath (
  input  logic               clk,
  input  logic               rst,
  input  plid_pkg::ctrl_t    ctrl,
  input  plid_pkg::req_t     request,
  output plid_pkg::result_t  result
);

  plid_pkg::req_t                         req;
  logic [plid_pkg::DATA_WIDTH-1:0]        elements [plid_pkg::DEPTH];
  logic [plid_pkg::DATA_WIDTH-1:0]        elements_next [plid_pkg::DEPTH];
  logic [plid_pkg::CNT_W-1:0]             count;
  logic [plid_pkg::CNT_W-1:0]             count_next;
  logic [plid_pkg::CMP_W-1:0]             pos;
  logic [plid_pkg::CMP_W-1:0]             pos_m1;
  logic [plid_pkg::CMP_W-1:0]             cnt;
  logic [plid_pkg::DATA_WIDTH-1:0]        val_ext;
  logic [plid_pkg::DATA_WIDTH-1:0]        picked;
  plid_pkg::status_t                      status;
  logic                                   do_ins;
  logic                                   do_del;

  assign pos     = plid_pkg::CMP_W'(req.position);
  assign pos_m1  = pos - plid_pkg::CMP_W'(1);
  assign cnt     = plid_pkg::CMP_W'(count);
  assign val_ext = plid_pkg::DATA_WIDTH'(req.value);
  assign picked  = elements[pos_m1[plid_pkg::IDX_W-1:0]];

  always_comb begin
    status = plid_pkg::STATUS_DONE;
    do_ins = 1'b0;
    do_del = 1'b0;
    if (req.command == plid_pkg::CMD_INSERT) begin
      if (pos > cnt) begin
        status = plid_pkg::STATUS_BAD_POSITION;
      end else if (count == plid_pkg::CNT_W'(plid_pkg::DEPTH)) begin
        status = plid_pkg::STATUS_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end else begin
      if (pos == '0 || pos > cnt) begin
        status = plid_pkg::STATUS_BAD_POSITION;
      end else begin
        do_del = 1'b1;
      end
    end
  end

  // Slots past the length always hold zero, so every cell above the slot shifts.
  always_comb begin
    for (int i = 0; i < plid_pkg::DEPTH; i++) begin
      elements_next[i] = elements[i];
      if (do_ins) begin
        if (plid_pkg::CMP_W'(i) == pos) begin
          elements_next[i] = val_ext;
        end else if (plid_pkg::CMP_W'(i) > pos) begin
          elements_next[i] = elements[i-1];
        end
      end else if (do_del) begin
        if (plid_pkg::CMP_W'(i) >= pos_m1) begin
          if (i == plid_pkg::DEPTH - 1) begin
            elements_next[i] = '0;
          end else begin
            elements_next[i] = elements[i+1];
          end
        end
      end
    end
    count_next = count;
    if (do_ins) begin
      count_next = count + plid_pkg::CNT_W'(1);
    end else if (do_del) begin
      count_next = count - plid_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req <= request;
    end
    if (ctrl.exec) begin
      result.status        <= status;
      result.removed_value <= do_del ? 32'(picked) : '0;
      result.length_after  <= 5'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < plid_pkg::DEPTH; i++) begin
        elements[i] <= '0;
      end
    end else if (ctrl.exec) begin
      count <= count_next;
      for (int i = 0; i < plid_pkg::DEPTH; i++) begin
        elements[i] <= elements_next[i];
      end
    end
  end

endmodule

[rtl/core/positional_list_insert_delete.sv]
// Positional list top level: controller and datapath. Depends on plid_pkg,
// plid_ctrl and plid_datapath.
// Sequence: the request is captured at the accepting edge, then the element
// cells, length, result and done are registered at the end of the execute
// state. No request is taken while busy (execute state), so each one is done
// before the next; the next request is taken while done is high.
// Reset clears the list and its length; the receiver cannot stall results.
module positional_list_insert_delete (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  plid_pkg::req_t     request,
  output logic               done,
  output plid_pkg::result_t  result
);

  plid_pkg::ctrl_t ctrl;

  plid_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  plid_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .request (request),
    .result  (result)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for positional_list_insert_delete: directed and random
// insert/delete requests, each result checked against an in-bench list model.
// Depends on plid_pkg and the positional_list_insert_delete top level.
module tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED  = 100;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  plid_pkg::req_t    request = '0;
  logic              busy;
  logic              done;
  plid_pkg::result_t result;

  logic signed [plid_pkg::DATA_WIDTH-1:0] list_elems [plid_pkg::DEPTH];
  int                list_len;
  plid_pkg::result_t outcome_q [$];
  plid_pkg::result_t head;
  int      mismatches = 0;
  int      cycles = 0;
  int      idle_pct = 0;

  always #4 clk = ~clk;

  positional_list_insert_delete dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  function automatic plid_pkg::req_t make_req(input logic cmd, input int pos,
                                              input logic signed [31:0] val);
    plid_pkg::req_t r;
    r.command  = cmd;
    r.position = pos[plid_pkg::POS_W-1:0];
    r.value    = val;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Apply one request to the list model and return the result it yields.
  function automatic plid_pkg::result_t apply_list_command(input plid_pkg::req_t req);
    plid_pkg::result_t r;
    int                pos;
    r   = '0;
    pos = int'(req.position);
    if (req.command == plid_pkg::CMD_INSERT) begin
      if (pos > list_len) begin
        r.status = plid_pkg::STATUS_BAD_POSITION;
      end else if (list_len >= plid_pkg::DEPTH) begin
        r.status = plid_pkg::STATUS_FULL;
      end else begin
        for (int i = list_len; i > pos; i--) list_elems[i] = list_elems[i-1];
        list_elems[pos] = req.value;
        list_len++;
      end
    end else begin
      if (pos == 0 || pos > list_len) begin
        r.status = plid_pkg::STATUS_BAD_POSITION;
      end else begin
        r.removed_value = list_elems[pos-1];
        for (int i = pos - 1; i + 1 < list_len; i++) list_elems[i] = list_elems[i+1];
        list_len--;
        list_elems[list_len] = '0;
      end
    end
    r.length_after = list_len[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
    mismatches++;
  endtask

  task automatic send_request(input plid_pkg::req_t req);
    if (int'($urandom_range(0, 99)) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    outcome_q.push_back(apply_list_command(req));
  endtask

  // Hold off new requests until every pending result has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_request(make_req(plid_pkg::CMD_DELETE, 0, 32'sd5));
    send_request(make_req(plid_pkg::CMD_DELETE, 1, 32'sd5));
    send_request(make_req(plid_pkg::CMD_INSERT, 1, 32'sd7));
    send_request(make_req(plid_pkg::CMD_DELETE, 31, -32'sd1));
  endtask

  task automatic test_value_extremes();
    send_request(make_req(plid_pkg::CMD_INSERT, 0, 32'sh8000_0000));
    send_request(make_req(plid_pkg::CMD_INSERT, 1, 32'sh7fff_ffff));
    send_request(make_req(plid_pkg::CMD_INSERT, 1, -32'sd1));
    send_request(make_req(plid_pkg::CMD_DELETE, 0, 32'sd0));
    send_request(make_req(plid_pkg::CMD_DELETE, 4, 32'sd0));
    send_request(make_req(plid_pkg::CMD_INSERT, 31, 32'sd3));
    send_request(make_req(plid_pkg::CMD_DELETE, 2, 32'sd0));
    send_request(make_req(plid_pkg::CMD_DELETE, 2, 32'sd0));
    send_request(make_req(plid_pkg::CMD_DELETE, 1, 32'sd0));
  endtask

  task automatic test_full_list();
    while (list_len < plid_pkg::DEPTH) begin
      send_request(make_req(plid_pkg::CMD_INSERT, int'($urandom_range(0, list_len)),
                            pick_value()));
    end
    send_request(make_req(plid_pkg::CMD_INSERT, plid_pkg::DEPTH, 32'sd1));
    send_request(make_req(plid_pkg::CMD_INSERT, plid_pkg::DEPTH + 1, 32'sd1));
    send_request(make_req(plid_pkg::CMD_INSERT, 0, 32'sd1));
    send_request(make_req(plid_pkg::CMD_DELETE, plid_pkg::DEPTH, 32'sd0));
    send_request(make_req(plid_pkg::CMD_DELETE, 1, 32'sd0));
  endtask

  task automatic test_random_mix(input int count, input int gap_pct);
    plid_pkg::req_t req;
    int             target;
    idle_pct = gap_pct;
    target   = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        target = int'($urandom_range(0, plid_pkg::DEPTH));
      end
      req.command = (list_len < target) ? plid_pkg::CMD_INSERT : plid_pkg::CMD_DELETE;
      if ($urandom_range(0, 3) == 0) begin
        req.command = ~req.command;
      end
      if ($urandom_range(0, 99) < 12) begin
        req.position = plid_pkg::POS_W'($urandom_range(0, 31));
      end else if (req.command == plid_pkg::CMD_INSERT) begin
        req.position = plid_pkg::POS_W'($urandom_range(0, list_len));
      end else begin
        req.position = (list_len == 0) ? '0 :
                       plid_pkg::POS_W'($urandom_range(1, list_len));
      end
      req.value = pick_value();
      send_request(req);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        head = outcome_q.pop_front();
        if (result.status !== head.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    result.status, head.status));
        end
        if (result.removed_value !== head.removed_value) begin
          report_mismatch($sformatf("removed_value %0d, expected %0d",
                                    result.removed_value, head.removed_value));
        end
        if (result.length_after !== head.length_after) begin
          report_mismatch($sformatf("length_after %0d, expected %0d",
                                    result.length_after, head.length_after));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAIL positional_list_insert_delete");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < plid_pkg::DEPTH; i++) list_elems[i] = '0;
    list_len = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_value_extremes();
    test_full_list();
    wait_drained();
    test_random_mix(517, 33);
    wait_drained();
    test_random_mix(517, 47);
    wait_drained();
    test_random_mix(516, 0);
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS positional_list_insert_delete");
    end else begin
      $display("FAIL positional_list_insert_delete");
    end
    $finish;
  end

endmodule

[positional_list_insert_delete.f]
rtl/core/plid_pkg.sv
rtl/core/plid_ctrl.sv
rtl/core/plid_datapath.sv
rtl/core/positional_list_insert_delete.sv
verif/tb.sv
